FILE: rtl/oks_pkg.sv
// ----------------------------------------------------------------------------
// Ordered key set table package
// Request codes, fixed field widths and the token that walks the cell row.
// ----------------------------------------------------------------------------
package oks_pkg;

    localparam int FUNC_WIDTH      = 2;
    localparam int KEY_FIELD_WIDTH = 32;
    localparam int POS_WIDTH       = 4;
    localparam int ENTRY_WIDTH     = 32;
    localparam int COUNT_WIDTH     = 5;

    localparam logic [FUNC_WIDTH-1:0] FUNC_CONTAINS = 2'd0;
    localparam logic [FUNC_WIDTH-1:0] FUNC_ADD      = 2'd1;
    localparam logic [FUNC_WIDTH-1:0] FUNC_REMOVE   = 2'd2;
    localparam logic [FUNC_WIDTH-1:0] FUNC_GET      = 2'd3;

    // Token handed from cell to cell, one cell per cycle.
    typedef struct packed {
        logic                   active;
        logic                   found;
        logic                   got;
        logic [ENTRY_WIDTH-1:0] entry;
    } oks_tok_t;

endpackage

FILE: rtl/oks_req_if.sv
// ----------------------------------------------------------------------------
// Ordered key set table request channel
// Valid/ready channel carrying one request: kind, key and position.
// ----------------------------------------------------------------------------
interface oks_req_if import oks_pkg::*; ();

    logic                              valid;
    logic                              ready;
    logic [FUNC_WIDTH-1:0]             func;
    logic signed [KEY_FIELD_WIDTH-1:0] key;
    logic [POS_WIDTH-1:0]              position;

    modport source (
        output valid,
        output func,
        output key,
        output position,
        input  ready
    );

    modport sink (
        input  valid,
        input  func,
        input  key,
        input  position,
        output ready
    );

endinterface

FILE: rtl/oks_rsp_if.sv
// ----------------------------------------------------------------------------
// Ordered key set table response channel
// Valid/ready channel carrying one result per request.
// ----------------------------------------------------------------------------
interface oks_rsp_if import oks_pkg::*; ();

    logic                          valid;
    logic                          ready;
    logic                          hit;
    logic                          added;
    logic                          full_refused;
    logic signed [ENTRY_WIDTH-1:0] entry;
    logic [COUNT_WIDTH-1:0]        count;

    modport source (
        output valid,
        output hit,
        output added,
        output full_refused,
        output entry,
        output count,
        input  ready
    );

    modport sink (
        input  valid,
        input  hit,
        input  added,
        input  full_refused,
        input  entry,
        input  count,
        output ready
    );

endinterface

FILE: rtl/oks_cell.sv
// ----------------------------------------------------------------------------
// Ordered key set table cell
// Holds one table entry, compares it with the broadcast key when the token
// passes, and takes its neighbour's entry when its own or an earlier entry is removed.
// ----------------------------------------------------------------------------
module oks_cell import oks_pkg::*; #(
    parameter int KEY_WIDTH = 32,
    parameter int CNT_WIDTH = 5,
    parameter int INDEX     = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [FUNC_WIDTH-1:0] func,
    input  logic [KEY_WIDTH-1:0]  key,
    input  logic [POS_WIDTH-1:0]  position,
    input  logic [CNT_WIDTH-1:0]  count,
    input  oks_tok_t              tok_in,
    input  logic [KEY_WIDTH-1:0]  nbr_data,
    output oks_tok_t              tok_out,
    output logic [KEY_WIDTH-1:0]  data
);

    localparam int CMP_WIDTH = CNT_WIDTH + POS_WIDTH;

    logic [KEY_WIDTH-1:0] data_reg;
    logic [KEY_WIDTH-1:0] data_next;
    oks_tok_t             tok_reg;
    oks_tok_t             tok_next;
    logic                 occupied;
    logic                 is_match;
    logic                 at_position;
    logic                 at_tail;

    assign occupied    = CNT_WIDTH'(INDEX) < count;
    assign is_match    = occupied && (data_reg == key);
    assign at_position = occupied && (CMP_WIDTH'(position) == CMP_WIDTH'(INDEX));
    assign at_tail     = count == CNT_WIDTH'(INDEX);

    always_comb
    begin
        tok_next  = tok_in;
        data_next = data_reg;
        if (tok_in.active)
        begin
            case (func)
                FUNC_CONTAINS:
                begin
                    tok_next.found = tok_in.found | is_match;
                end
                FUNC_ADD:
                begin
                    tok_next.found = tok_in.found | is_match;
                    // Every occupied cell lies upstream of the tail, so the
                    // search is complete by the time the token gets here.
                    if (!tok_in.found && at_tail)
                    begin
                        data_next = key;
                    end
                end
                FUNC_REMOVE:
                begin
                    tok_next.found = tok_in.found | is_match;
                    if (occupied && (tok_in.found || is_match))
                    begin
                        data_next = nbr_data;
                    end
                end
                FUNC_GET:
                begin
                    if (at_position)
                    begin
                        tok_next.got   = 1'b1;
                        tok_next.entry = ENTRY_WIDTH'(data_reg);
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign tok_out = tok_reg;
    assign data    = data_reg;

endmodule

FILE: rtl/ordered_key_set_table_unit.sv
// ----------------------------------------------------------------------------
// Ordered key set table unit
// Table of distinct keys in insertion order, held in a row of cells that a
// request token walks through one cell per cycle.
// ----------------------------------------------------------------------------
//  Channel | Direction | Payload                                  | Accepted when
//  req     | in        | func, key, position                      | valid && ready
//  rsp     | out       | hit, added, full_refused, entry, count   | valid && ready
//
// One request is in progress at a time; the next request can be accepted only
// after the token has stepped through the DEPTH cells one per cycle and the
// result has moved on to the output register.
// The result waits in the output register, so a stalled rsp does not stop
// the next request from being accepted. That request's result then waits in
// the pending registers, and no further request is taken until the first
// result has left.
// Reset clears the count and the control state; stored entries are left as
// they are and never read until written.
module ordered_key_set_table_unit import oks_pkg::*; #(
    parameter int DEPTH     = 16,
    parameter int KEY_WIDTH = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    oks_req_if.sink    req,
    oks_rsp_if.source  rsp
);

    localparam int CNT_WIDTH = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]             state_reg;
    logic [1:0]             state_next;
    logic                   start_reg;
    logic [CNT_WIDTH-1:0]   count_reg;
    logic [CNT_WIDTH-1:0]   count_next;
    logic [FUNC_WIDTH-1:0]  func_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [POS_WIDTH-1:0]   pos_reg;

    logic                   pend_hit_reg;
    logic                   pend_added_reg;
    logic                   pend_full_reg;
    logic [ENTRY_WIDTH-1:0] pend_entry_reg;

    logic                   rsp_valid_reg;
    logic                   rsp_hit_reg;
    logic                   rsp_added_reg;
    logic                   rsp_full_reg;
    logic [ENTRY_WIDTH-1:0] rsp_entry_reg;
    logic [COUNT_WIDTH-1:0] rsp_count_reg;

    logic                   req_fire;
    logic                   finish;
    logic                   load_rsp;
    logic                   res_hit;
    logic                   res_added;
    logic                   res_full;

    oks_tok_t               tok [DEPTH+1];
    logic [KEY_WIDTH-1:0]   cell_data [DEPTH];

    assign req.ready = state_reg == ST_IDLE;
    assign req_fire  = req.valid && req.ready;
    assign finish    = (state_reg == ST_RUN) && tok[DEPTH].active;
    assign load_rsp  = (state_reg == ST_DRAIN) && (!rsp_valid_reg || rsp.ready);

    always_comb
    begin
        tok[0]        = '0;
        tok[0].active = start_reg;
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [KEY_WIDTH-1:0] nbr;

        if (i == DEPTH - 1)
        begin : g_last
            assign nbr = cell_data[i];
        end
        else
        begin : g_mid
            assign nbr = cell_data[i+1];
        end

        oks_cell #(
            .KEY_WIDTH (KEY_WIDTH),
            .CNT_WIDTH (CNT_WIDTH),
            .INDEX     (i)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .func     (func_reg),
            .key      (key_reg),
            .position (pos_reg),
            .count    (count_reg),
            .tok_in   (tok[i]),
            .nbr_data (nbr),
            .tok_out  (tok[i+1]),
            .data     (cell_data[i])
        );
    end

    // Outcome once the token leaves the last cell.
    always_comb
    begin
        res_hit    = 1'b0;
        res_added  = 1'b0;
        res_full   = 1'b0;
        count_next = count_reg;
        case (func_reg)
            FUNC_CONTAINS:
            begin
                res_hit = tok[DEPTH].found;
            end
            FUNC_ADD:
            begin
                res_hit = tok[DEPTH].found;
                if (!tok[DEPTH].found)
                begin
                    if (count_reg == CNT_WIDTH'(DEPTH))
                    begin
                        res_full = 1'b1;
                    end
                    else
                    begin
                        res_added  = 1'b1;
                        count_next = count_reg + CNT_WIDTH'(1);
                    end
                end
            end
            FUNC_REMOVE:
            begin
                res_hit = tok[DEPTH].found;
                if (tok[DEPTH].found)
                begin
                    count_next = count_reg - CNT_WIDTH'(1);
                end
            end
            FUNC_GET:
            begin
                res_hit = tok[DEPTH].got;
            end
            default:
            begin
                res_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (finish)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (load_rsp)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            start_reg     <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= req_fire;
            if (finish)
            begin
                count_reg <= count_next;
            end
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            func_reg <= req.func;
            key_reg  <= KEY_WIDTH'($unsigned(req.key));
            pos_reg  <= req.position;
        end
        if (finish)
        begin
            pend_hit_reg   <= res_hit;
            pend_added_reg <= res_added;
            pend_full_reg  <= res_full;
            pend_entry_reg <= tok[DEPTH].entry;
        end
        if (load_rsp)
        begin
            rsp_hit_reg   <= pend_hit_reg;
            rsp_added_reg <= pend_added_reg;
            rsp_full_reg  <= pend_full_reg;
            rsp_entry_reg <= pend_entry_reg;
            rsp_count_reg <= COUNT_WIDTH'(count_reg);
        end
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.hit          = rsp_hit_reg;
    assign rsp.added        = rsp_added_reg;
    assign rsp.full_refused = rsp_full_reg;
    assign rsp.entry        = $signed(rsp_entry_reg);
    assign rsp.count        = rsp_count_reg;

endmodule
